// ----- rtl/core/yaz0_pkg.sv -----
// ----------------------------------------------------------------------------
// yaz0_pkg: shared types and constants of the Yaz0 decoder
// Holds the command that passes from the parser to the copy engine, plus
// the parser phase and engine state enums.
// ----------------------------------------------------------------------------
package yaz0_pkg;

  localparam int unsigned OutLanes   = 8;
  localparam int unsigned HistDepth  = 4096;
  localparam int unsigned HistAw     = 12;
  localparam int unsigned CmdqDepth  = 2;
  localparam logic [8:0]  LongLenAdd = 9'h012;
  localparam logic [8:0]  ShortLenAdd = 9'd2;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_BYTE1 = 2'd1,
    PH_BYTE2 = 2'd2,
    PH_EXTRA = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_ISSUE = 2'd1,
    BK_WRITE = 2'd2
  } back_state_e;

  // One run to produce: a literal or a copy, already clipped to the end.
  typedef struct packed {
    logic        is_lit;
    logic [7:0]  lit;
    logic [8:0]  len;
    logic [12:0] dist1;
    logic        bad;
    logic        done;
  } cmd_t;

endpackage

// ----- rtl/core/yaz0_ram.sv -----
// ----------------------------------------------------------------------------
// yaz0_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module yaz0_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/yaz0_front.sv -----
// ----------------------------------------------------------------------------
// yaz0_front: payload parser
// Tracks code bits and parse phase, builds one clipped run command per
// literal or back-reference and keeps the running output count.
// ----------------------------------------------------------------------------
module yaz0_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       expected_size_i,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  output logic              push_o,
  output yaz0_pkg::cmd_t    cmd_o
);

  logic [31:0]      exp_q;
  logic [31:0]      bw_q, bw_d;
  logic [7:0]       code_q, code_d;
  logic [3:0]       bits_q, bits_d;
  yaz0_pkg::phase_e phase_q, phase_d;
  logic [11:0]      dist_q, dist_d;
  logic [3:0]       nib_q, nib_d;

  logic        active;
  logic        emit;
  logic        is_lit;
  logic [8:0]  len_raw;
  logic [8:0]  len;
  logic [31:0] room;
  logic [12:0] dist1;
  logic [3:0]  bits_dec;

  always_comb begin
    active   = bw_q < exp_q;
    room     = exp_q - bw_q;
    code_d   = code_q;
    bits_d   = bits_q;
    phase_d  = phase_q;
    dist_d   = dist_q;
    nib_d    = nib_q;
    emit     = 1'b0;
    is_lit   = 1'b0;
    len_raw  = 9'd1;
    unique case (phase_q)
      yaz0_pkg::PH_CODE: begin
        code_d  = data_byte_i;
        bits_d  = 4'd8;
        phase_d = yaz0_pkg::PH_BYTE1;
      end
      yaz0_pkg::PH_BYTE1: begin
        if (code_q[7]) begin
          emit   = 1'b1;
          is_lit = 1'b1;
        end else begin
          nib_d   = data_byte_i[7:4];
          dist_d  = {data_byte_i[3:0], 8'h00};
          phase_d = yaz0_pkg::PH_BYTE2;
        end
      end
      yaz0_pkg::PH_BYTE2: begin
        dist_d = {dist_q[11:8], data_byte_i};
        if (nib_q != 4'd0) begin
          emit    = 1'b1;
          len_raw = {5'd0, nib_q} + yaz0_pkg::ShortLenAdd;
        end else begin
          phase_d = yaz0_pkg::PH_EXTRA;
        end
      end
      yaz0_pkg::PH_EXTRA: begin
        emit    = 1'b1;
        len_raw = {1'b0, data_byte_i} + yaz0_pkg::LongLenAdd;
      end
      default: ;
    endcase
    // advance to the next flag after any run
    bits_dec = (bits_q != 4'd0) ? bits_q - 4'd1 : 4'd0;
    if (emit) begin
      code_d  = {code_q[6:0], 1'b0};
      bits_d  = bits_dec;
      phase_d = (bits_dec == 4'd0) ? yaz0_pkg::PH_CODE : yaz0_pkg::PH_BYTE1;
    end
    len   = (room < {23'd0, len_raw}) ? room[8:0] : len_raw;
    dist1 = {1'b0, dist_d} + 13'd1;
    bw_d  = bw_q + {23'd0, len};
  end

  assign push_o       = accept_i && active && emit;
  assign cmd_o.is_lit = is_lit;
  assign cmd_o.lit    = data_byte_i;
  assign cmd_o.len    = len;
  assign cmd_o.dist1  = dist1;
  assign cmd_o.bad    = !is_lit && ({19'd0, dist1} > bw_q);
  assign cmd_o.done   = ({23'd0, len} == room);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= '0;
      bw_q    <= '0;
      code_q  <= '0;
      bits_q  <= '0;
      phase_q <= yaz0_pkg::PH_CODE;
      dist_q  <= '0;
      nib_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        exp_q <= expected_size_i;
      end
      if (accept_i && active) begin
        code_q  <= code_d;
        bits_q  <= bits_d;
        phase_q <= phase_d;
        dist_q  <= dist_d;
        nib_q   <= nib_d;
        if (emit) begin
          bw_q <= bw_d;
        end
      end
    end
  end

endmodule

// ----- rtl/core/yaz0_cmdq.sv -----
// ----------------------------------------------------------------------------
// yaz0_cmdq: run command queue
// Small flip-flop FIFO between the parser and the copy engine.
// ----------------------------------------------------------------------------
module yaz0_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  yaz0_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output yaz0_pkg::cmd_t cmd_o
);

  localparam int unsigned Aw = $clog2(yaz0_pkg::CmdqDepth);

  yaz0_pkg::cmd_t  slot_q [yaz0_pkg::CmdqDepth];
  logic [Aw-1:0]   wp_q, rp_q;
  logic [Aw:0]     cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(yaz0_pkg::CmdqDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == Aw'(yaz0_pkg::CmdqDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == Aw'(yaz0_pkg::CmdqDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("command queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Aw+1)'(yaz0_pkg::CmdqDepth)) else $error("queue count out of range");

endmodule

// ----- rtl/core/yaz0_back.sv -----
// ----------------------------------------------------------------------------
// yaz0_back: copy engine
// Executes run commands a byte at a time through the history RAM, packs
// bytes into eight lanes and holds each result in an output register.
// ----------------------------------------------------------------------------
module yaz0_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  yaz0_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [63:0]    data_lanes_o,
  output logic [3:0]     byte_count_o,
  output logic           last_of_run_o,
  output logic           stream_done_o,
  output logic           bad_distance_o
);

  yaz0_pkg::back_state_e state_q, state_d;
  yaz0_pkg::cmd_t        cmd_q;
  logic [8:0]            rem_q;
  logic [2:0]            fill_q;
  logic [63:0]           lanes_q;
  logic [yaz0_pkg::HistAw-1:0] wp_q;

  logic        out_valid_q;
  logic [63:0] out_lanes_q;
  logic [3:0]  out_cnt_q;
  logic        out_last_q, out_done_q, out_bad_q;

  logic        out_free;
  logic        closes;
  logic        step;
  logic [7:0]  rd_data;
  logic [7:0]  byte_val;
  logic [63:0] lanes_new;
  logic        ram_we, ram_re;
  logic [yaz0_pkg::HistAw-1:0] ram_addr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign closes   = (fill_q == 3'(yaz0_pkg::OutLanes - 1)) || (rem_q == 9'd1);
  assign step     = (state_q == yaz0_pkg::BK_WRITE) && (!closes || out_free);
  assign byte_val = cmd_q.is_lit ? cmd_q.lit : (cmd_q.bad ? 8'h00 : rd_data);

  always_comb begin
    lanes_new = lanes_q;
    lanes_new[{fill_q, 3'b000} +: 8] = byte_val;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      yaz0_pkg::BK_IDLE:  if (cmd_valid_i) state_d = yaz0_pkg::BK_ISSUE;
      yaz0_pkg::BK_ISSUE: state_d = yaz0_pkg::BK_WRITE;
      yaz0_pkg::BK_WRITE: begin
        if (step) begin
          state_d = (rem_q == 9'd1) ? yaz0_pkg::BK_IDLE : yaz0_pkg::BK_ISSUE;
        end
      end
      default: state_d = yaz0_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = wp_q;
    unique case (state_q)
      yaz0_pkg::BK_IDLE:  pop_o = cmd_valid_i;
      yaz0_pkg::BK_ISSUE: begin
        ram_re   = !cmd_q.is_lit && !cmd_q.bad;
        ram_addr = wp_q - cmd_q.dist1[yaz0_pkg::HistAw-1:0];
      end
      yaz0_pkg::BK_WRITE: ram_we = step;
      default: ;
    endcase
  end

  yaz0_ram #(
    .Width (8),
    .Depth (yaz0_pkg::HistDepth)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (byte_val),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (step && closes) begin
      out_lanes_q <= lanes_new;
      out_cnt_q   <= {1'b0, fill_q} + 4'd1;
      out_last_q  <= (rem_q == 9'd1);
      out_done_q  <= (rem_q == 9'd1) && cmd_q.done;
      out_bad_q   <= cmd_q.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= yaz0_pkg::BK_IDLE;
      rem_q       <= '0;
      fill_q      <= '0;
      lanes_q     <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        rem_q <= cmd_i.len;
      end
      if (step) begin
        wp_q  <= wp_q + 1'b1;
        rem_q <= rem_q - 9'd1;
        if (closes) begin
          fill_q  <= '0;
          lanes_q <= '0;
        end else begin
          fill_q  <= fill_q + 3'd1;
          lanes_q <= lanes_new;
        end
      end
      if (step && closes) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_lanes_o   = out_lanes_q;
  assign byte_count_o   = out_cnt_q;
  assign last_of_run_o  = out_last_q;
  assign stream_done_o  = out_done_q;
  assign bad_distance_o = out_bad_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o != 4'd0) && (byte_count_o <= 4'd8))
    else $error("byte_count out of range");
  a_issue_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == yaz0_pkg::BK_ISSUE |=> state_q == yaz0_pkg::BK_WRITE)
    else $error("read not followed by write");
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_done_o |-> last_of_run_o)
    else $error("stream_done on a non-final result");

endmodule

// ----- rtl/core/yaz0_lz_decoder_top.sv -----
// ----------------------------------------------------------------------------
// yaz0_lz_decoder_top: Yaz0 payload decoder
// Parses compressed bytes into run commands and replays them through a
// 4096-byte history, giving up to eight decoded bytes per result.
// ----------------------------------------------------------------------------
// Usage:
//   Write expected_size_i with cfg_we_i while idle; until then (reset value
//   zero) every input byte is taken and dropped.
//   Input channel: data_byte_i with in_valid_i / in_stall_o, one compressed
//   payload byte (the part after the header) per transaction.
//   Output channel: out_valid_o / out_stall_i, each transaction carries
//   data_lanes_o (first byte in bits 7:0, unused lanes zero), byte_count_o,
//   last_of_run_o, stream_done_o and bad_distance_o.
//   Throughput: the parser takes a byte per cycle while the two-entry
//   command queue has room. The copy engine handles each decoded byte in
//   its issue state (read the history RAM) and then its write state (write
//   it back and pack), a closing write waiting while a stalled result holds
//   the output register; it starts the next byte only after that write.
//   A stalled receiver holds the output register; the engine keeps filling
//   its lane buffer and stops when the next result is ready, and the queue
//   then backs up into in_stall_o.
//   Reset clears all control state; the history RAM is not cleared, since a
//   reference that reaches before the first output byte yields zeros.
// ----------------------------------------------------------------------------
module yaz0_lz_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] expected_size_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] data_lanes_o,
  output logic [3:0]  byte_count_o,
  output logic        last_of_run_o,
  output logic        stream_done_o,
  output logic        bad_distance_o
);

  logic           accept;
  logic           push, pop, full, empty;
  yaz0_pkg::cmd_t cmd_in, cmd_out;

  // Hold input while the command queue is full.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  yaz0_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .expected_size_i (expected_size_i),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  yaz0_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  yaz0_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (!empty),
    .cmd_i          (cmd_out),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_lanes_o   (data_lanes_o),
    .byte_count_o   (byte_count_o),
    .last_of_run_o  (last_of_run_o),
    .stream_done_o  (stream_done_o),
    .bad_distance_o (bad_distance_o)
  );

endmodule

// ----- dv/tb_yaz0_lz_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yaz0_lz_decoder_top: self-checking bench for the Yaz0 payload decoder
// Feeds compressed payload bytes under random valid gaps and output stalls,
// predicts every packed result from its own copy of the parser, history ring
// and byte counter, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module tb_yaz0_lz_decoder_top;

  typedef struct {
    logic [63:0] lanes;
    logic [3:0]  count;
    logic        last;
    logic        done;
    logic        bad;
  } decoded_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] expected_size_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] data_lanes_o;
  logic [3:0]  byte_count_o;
  logic        last_of_run_o;
  logic        stream_done_o;
  logic        bad_distance_o;

  yaz0_lz_decoder_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .expected_size_i(expected_size_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_lanes_o   (data_lanes_o),
    .byte_count_o   (byte_count_o),
    .last_of_run_o  (last_of_run_o),
    .stream_done_o  (stream_done_o),
    .bad_distance_o (bad_distance_o)
  );

  // Stimulus queue and expected decoded results.
  logic [7:0] payload_q[$];
  decoded_t   decoded_q[$];

  // Decoder shadow state.
  logic [31:0]      size_limit;
  logic [7:0]       flag_bits;
  logic [3:0]       flags_left;
  yaz0_pkg::phase_e parse_ph;
  logic [11:0]      ref_dist;
  logic [3:0]       ref_nibble;
  logic [31:0]      out_total;
  logic [7:0]       hist_ring[yaz0_pkg::HistDepth];
  logic [11:0]      hist_wp;

  int unsigned err_cnt;
  int unsigned bytes_in;
  int unsigned results_seen;
  int unsigned bad_seen;
  int unsigned stall_cnt;
  int unsigned gap_cnt;
  int unsigned hold_cnt;
  int unsigned idle_cycles;
  bit          no_idle;
  bit          in_fire;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Replay one run through the history ring, packing up to OutLanes bytes per result.
  task automatic emit_run(input int unsigned len, input bit is_lit, input logic [7:0] lit);
    logic [12:0] dist1;
    bit          bad;
    logic [31:0] room;
    logic [7:0]  b;
    decoded_t    r;
    int unsigned fill;
    dist1 = {1'b0, ref_dist} + 13'd1;
    bad   = !is_lit && (32'(dist1) > out_total);
    room  = size_limit - out_total;
    fill  = 0;
    r.lanes = '0;
    if (len > room) len = room;
    for (int unsigned i = 0; i < len; i++) begin
      if (is_lit) b = lit;
      else if (bad) b = 8'h00;
      else b = hist_ring[12'(hist_wp - dist1[11:0])];
      hist_ring[hist_wp] = b;
      hist_wp = hist_wp + 12'd1;
      out_total = out_total + 32'd1;
      r.lanes[8*fill +: 8] = b;
      fill++;
      if (fill == yaz0_pkg::OutLanes || i + 1 == len) begin
        r.count = 4'(fill);
        r.last  = (i + 1 == len);
        r.done  = (out_total == size_limit);
        r.bad   = bad;
        decoded_q.push_back(r);
        r.lanes = '0;
        fill    = 0;
      end
    end
    // Advance to the next flag bit or back to a code byte.
    flag_bits = flag_bits << 1;
    if (flags_left > 0) flags_left--;
    parse_ph = (flags_left == 0) ? yaz0_pkg::PH_CODE : yaz0_pkg::PH_BYTE1;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (out_total >= size_limit) return;
    case (parse_ph)
      yaz0_pkg::PH_CODE: begin
        flag_bits  = b;
        flags_left = 4'd8;
        parse_ph   = yaz0_pkg::PH_BYTE1;
      end
      yaz0_pkg::PH_BYTE1: begin
        if (flag_bits[7]) begin
          emit_run(1, 1'b1, b);
        end else begin
          ref_nibble = b[7:4];
          ref_dist   = {b[3:0], 8'h00};
          parse_ph   = yaz0_pkg::PH_BYTE2;
        end
      end
      yaz0_pkg::PH_BYTE2: begin
        ref_dist[7:0] = b;
        if (ref_nibble != 4'd0) begin
          emit_run(int'(ref_nibble) + int'(yaz0_pkg::ShortLenAdd), 1'b0, 8'h00);
        end else begin
          parse_ph = yaz0_pkg::PH_EXTRA;
        end
      end
      default: emit_run(int'(b) + int'(yaz0_pkg::LongLenAdd), 1'b0, 8'h00);
    endcase
  endtask

  // Driver: change inputs on the falling edge; hold the payload while stalled.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (gap_cnt > 0) begin
        in_valid_i <= 1'b0;
        gap_cnt--;
      end else if (payload_q.size() > 0) begin
        data_byte_i <= payload_q.pop_front();
        in_valid_i  <= 1'b1;
        gap_cnt = no_idle ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: sample both channels on the rising edge.
  always @(posedge clk_i) begin
    decoded_t e;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(data_byte_i);
        bytes_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        hold_cnt = no_idle ? 0 : $urandom_range(0, 17);
        if (decoded_q.size() == 0) begin
          $error("unexpected result transaction: lanes %h count %0d", data_lanes_o, byte_count_o);
          err_cnt++;
        end else begin
          e = decoded_q.pop_front();
          if (e.bad) bad_seen++;
          if (data_lanes_o !== e.lanes) begin
            $error("data_lanes: expected %h actual %h", e.lanes, data_lanes_o);
            err_cnt++;
          end
          if (byte_count_o !== e.count) begin
            $error("byte_count: expected %0d actual %0d", e.count, byte_count_o);
            err_cnt++;
          end
          if (last_of_run_o !== e.last) begin
            $error("last_of_run: expected %0b actual %0b", e.last, last_of_run_o);
            err_cnt++;
          end
          if (stream_done_o !== e.done) begin
            $error("stream_done: expected %0b actual %0b", e.done, stream_done_o);
            err_cnt++;
          end
          if (bad_distance_o !== e.bad) begin
            $error("bad_distance: expected %0b actual %0b", e.bad, bad_distance_o);
            err_cnt++;
          end
        end
      end
      // Watchdog: count cycles with no transaction on either side.
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired with %0d results outstanding", decoded_q.size());
        $display("tb_yaz0_lz_decoder_top: FAIL");
        $finish;
      end
    end
  end

  // Wait for the input queue and the expected results to drain, then let the
  // engine settle before touching the register.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (payload_q.size() > 0 || in_valid_i || decoded_q.size() > 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i        <= 1'b1;
    expected_size_i <= val;
    size_limit = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Queue a reference: nibble, 12-bit distance, extra length when nibble is zero.
  task automatic push_ref(input logic [3:0] nib, input logic [11:0] distance,
                          input logic [7:0] extra);
    payload_q.push_back({nib, distance[11:8]});
    payload_q.push_back(distance[7:0]);
    if (nib == 4'd0) payload_q.push_back(extra);
  endtask

  // Queue one well-formed group: a code byte and its eight items, with
  // occasional noise bytes that knock the parse out of step.
  task automatic push_group();
    logic [7:0]  code;
    logic [11:0] distance;
    logic [7:0]  extra;
    int unsigned sel;
    code = $urandom();
    payload_q.push_back(code);
    for (int k = 7; k >= 0; k--) begin
      if ($urandom_range(0, 39) == 0) payload_q.push_back($urandom());
      if (code[k]) begin
        payload_q.push_back($urandom());
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 7) distance = $urandom_range(0, 63);
        else if (sel < 9) distance = $urandom();
        else distance = 12'hFFF;
        extra = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 15));
        push_ref(($urandom_range(0, 4) == 0) ? 4'd0 : 4'($urandom()), distance, extra);
      end
    end
  endtask

  task automatic random_phase(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = payload_q.size() + n_bytes;
    while (payload_q.size() < stop_at) push_group();
    wait_idle();
  endtask

  initial begin
    cfg_we_i = 1'b0;  expected_size_i = '0;
    in_valid_i = 1'b0;  data_byte_i = '0;  out_stall_i = 1'b0;
    in_fire = 1'b0;
    size_limit = '0;  flag_bits = '0;  flags_left = '0;  parse_ph = yaz0_pkg::PH_CODE;
    ref_dist = '0;  ref_nibble = '0;  out_total = '0;  hist_wp = '0;
    err_cnt = 0;  bytes_in = 0;  results_seen = 0;  bad_seen = 0;
    stall_cnt = 0;  gap_cnt = 0;  hold_cnt = 0;  idle_cycles = 0;  no_idle = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Size still zero after reset: these bytes must all be dropped.
    payload_q.push_back(8'h80); payload_q.push_back(8'h11); payload_q.push_back(8'hFF);
    wait_idle();

    // Directed: extreme literals, a reference reaching before the start, the
    // longest and shortest lengths, then a short run within the size limit.
    write_size(32'd320);
    payload_q.push_back(8'hC0);
    payload_q.push_back(8'h00);
    payload_q.push_back(8'hFF);
    push_ref(4'h0, 12'hFFF, 8'h00);   // distance before start, long form
    push_ref(4'hF, 12'h000, 8'h00);   // longest short run, distance one
    push_ref(4'h1, 12'h002, 8'h00);   // shortest run
    push_ref(4'h0, 12'h010, 8'hFF);   // longest run
    push_ref(4'h2, 12'h001, 8'h00);   // short run, distance two, still within the limit
    wait_idle();

    // Size zero again: everything is ignored.
    write_size(32'd0);
    payload_q.push_back(8'h5A); payload_q.push_back(8'hA5);
    wait_idle();

    // Random phases, each with a new size limit, with and without idling.
    for (int p = 0; p < 3; p++) begin
      no_idle = (p == 1);
      write_size(out_total + $urandom_range(200, 2500));
      random_phase(100);
    end

    // Largest size: the stream never completes.
    no_idle = 1'b0;
    write_size(32'hFFFF_FFFF);
    random_phase(100);

    repeat (DrainCycles) @(negedge clk_i);
    $display("covered %0d payload bytes, %0d results (%0d with bad distance),",
             bytes_in, results_seen, bad_seen);
    $display("%0d decoded bytes, %0d leftover expectations", out_total, decoded_q.size());
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("tb_yaz0_lz_decoder_top: PASS");
    end else begin
      $display("tb_yaz0_lz_decoder_top: FAIL");
    end
    $finish;
  end

endmodule
